>>> hw/rtl/wiu_pkg.sv
// ----------------------------------------------------------------------------
// wiu_pkg
// Shared types and constants for the wide integer word ALU: command codes,
// sequencer states, compare codes and the control and result bundles of the
// shared word unit.
// ----------------------------------------------------------------------------
package wiu_pkg;

  // Width of one word of a wide value.
  localparam int WORD_W = 64;

  // Word count after reset.
  localparam logic [3:0] WORDS_RESET = 4'd8;

  // Compare outcome codes (two's complement -1, 0, 1).
  localparam logic [1:0] CMP_EQ = 2'b00;
  localparam logic [1:0] CMP_GT = 2'b01;
  localparam logic [1:0] CMP_LT = 2'b11;

  // Request command codes.
  typedef enum logic [3:0] {
    CMD_WRACC  = 4'd0,
    CMD_WROPND = 4'd1,
    CMD_RDACC  = 4'd2,
    CMD_ADD    = 4'd3,
    CMD_ADDSC  = 4'd4,
    CMD_CMP    = 4'd5,
    CMD_SHL    = 4'd6,
    CMD_OR     = 4'd7,
    CMD_AND    = 4'd8,
    CMD_SETALL = 4'd9,
    CMD_CLRALL = 4'd10
  } cmd_t;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  // Control for one pass of the shared word unit.
  typedef struct packed {
    cmd_t       cmd;
    logic       first;
    logic       carry;
    logic [5:0] rem;
  } wu_ctl_t;

  // Outcome of one pass of the shared word unit.
  typedef struct packed {
    logic [WORD_W-1:0] wdata;
    logic              carry;
    logic [1:0]        cmp;
  } wu_res_t;

endpackage

>>> hw/rtl/wiu_ram.sv
// ----------------------------------------------------------------------------
// wiu_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module wiu_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/wiu_word_unit.sv
// ----------------------------------------------------------------------------
// wiu_word_unit
// Shared 64-bit word unit: one adder with carry, the bitwise operations,
// a funnel shifter for the left shift and an unsigned word compare.
// ----------------------------------------------------------------------------
module wiu_word_unit
  import wiu_pkg::*;
(
  input  wu_ctl_t           ctl,
  input  logic [WORD_W-1:0] acc_word,
  input  logic [WORD_W-1:0] opd_word,
  input  logic [WORD_W-1:0] hi_word,
  input  logic [WORD_W-1:0] scalar,
  output wu_res_t           res
);

  logic [WORD_W-1:0]   addend;
  logic [WORD_W:0]     sum;
  logic [2*WORD_W-1:0] funnel;

  // Pick the adder's second input: operand word, or the scalar on the first word.
  always_comb begin
    case (ctl.cmd)
      CMD_ADD:   addend = opd_word;
      CMD_ADDSC: addend = ctl.first ? scalar : '0;
      default:   addend = '0;
    endcase
  end

  assign sum    = {1'b0, acc_word} + {1'b0, addend} + (WORD_W+1)'(ctl.carry);
  // The upper half of the shifted pair is the new word; the lower word
  // supplies the bits that cross the word boundary.
  assign funnel = {hi_word, acc_word} << ctl.rem;

  // Select the word written back.
  always_comb begin
    case (ctl.cmd)
      CMD_ADD, CMD_ADDSC: res.wdata = sum[WORD_W-1:0];
      CMD_OR:             res.wdata = acc_word | opd_word;
      CMD_AND:            res.wdata = acc_word & opd_word;
      CMD_SETALL:         res.wdata = '1;
      CMD_CLRALL:         res.wdata = '0;
      CMD_SHL:            res.wdata = funnel[2*WORD_W-1:WORD_W];
      default:            res.wdata = acc_word;
    endcase
  end

  assign res.carry = sum[WORD_W];

  // Unsigned word compare.
  always_comb begin
    if (acc_word == opd_word) begin
      res.cmp = CMP_EQ;
    end else if (acc_word > opd_word) begin
      res.cmp = CMP_GT;
    end else begin
      res.cmp = CMP_LT;
    end
  end

endmodule

>>> hw/rtl/wide_integer_word_alu_unit.sv
// ----------------------------------------------------------------------------
// wide_integer_word_alu_unit
// Multiword ALU over a wide accumulator and a wide operand, each held in a
// word RAM, least significant word first. Whole-value commands walk the words
// one per cycle through a shared 64-bit word unit.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------
//   request  | start / busy         | in_command, in_word_index, in_value,
//            |                      | in_shift_distance
//   result   | out_valid (1 cycle)  | out_read_data, out_compare_result
//   config   | cfg_we               | cfg_wdata (words in use)
//
// Word writes, unused codes and a zero shift finish at once: busy stays low
// and the result appears the cycle after the request. A word read and the
// whole-value commands keep busy high while the sequencer walks the words
// one per cycle through the word RAM read port and then drains, and a new
// request is taken only once busy is low again. Reset is synchronous and
// clears the per-word valid flags, so both values read as zero until written.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module wide_integer_word_alu_unit
  import wiu_pkg::*;
#(
  parameter int MAX_WORDS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [3:0]               in_command,
  input  logic [2:0]               in_word_index,
  input  logic [63:0]              in_value,
  input  logic [11:0]              in_shift_distance,
  output logic                     out_valid,
  output logic [63:0]              out_read_data,
  output logic signed [1:0]        out_compare_result,
  input  logic                     cfg_we,
  input  logic [3:0]               cfg_wdata
);

  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CW = $clog2(MAX_WORDS + 1) + 1;
  localparam int KW = (CW > 4) ? CW : 4;
  localparam int SW = (CW + 6 > 12) ? CW + 6 : 12;
  localparam int VN = 2 ** AW;

  // Configuration and sequencer state.
  logic [3:0]        words_r;
  state_t            state_r;
  logic              out_valid_r;
  logic              dv_r;
  logic [VN-1:0]     acc_vld_r;
  logic [VN-1:0]     opd_vld_r;

  // Request context.
  cmd_t              cmd_r;
  logic [CW-1:0]     n_r;
  logic [CW-1:0]     last_r;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     base_r;
  logic [5:0]        rem_r;
  logic [63:0]       val_r;
  logic [AW-1:0]     idx_r;
  logic              idx_ok_r;

  // Data stage registers.
  logic [AW-1:0]     d_dst_r;
  logic              d_wr_r;
  logic              d_acc_use_r;
  logic              d_opd_use_r;
  logic              d_first_r;
  logic              carry_r;
  logic [1:0]        cr_r;
  logic [63:0]       hi_r;
  logic [63:0]       out_read_data_r;
  logic [1:0]        out_compare_r;

  // Request decode signals.
  logic [KW-1:0]     cfg_k;
  logic [KW-1:0]     n_k;
  logic [CW-1:0]     n_eff;
  logic              idx_ok;
  logic [AW-1:0]     in_addr;
  logic [SW-1:0]     dist_ext;
  logic [SW-1:0]     len_bits;
  logic              long_shift;
  logic              dist_zero;
  logic [CW-1:0]     off;
  logic              accept;
  cmd_t              in_cmd;
  cmd_t              cmd_go;
  logic              go_run;
  logic              go_imm;
  logic              acc_we_in;
  logic              opd_we_in;
  logic [CW-1:0]     last_go;

  // Issue stage signals.
  logic [AW-1:0]     iss_addr;
  logic [AW-1:0]     iss_dst;
  logic              iss_wr;
  logic              iss_acc_en;
  logic              iss_opd_en;
  logic              iss_acc_use;
  logic              iss_opd_use;

  // RAM and word unit signals.
  logic              acc_we;
  logic [AW-1:0]     acc_waddr;
  logic [63:0]       acc_wdata;
  logic [63:0]       acc_rdata;
  logic              opd_we;
  logic [63:0]       opd_rdata;
  logic [63:0]       acc_word;
  logic [63:0]       opd_word;
  wu_ctl_t           wu_ctl;
  wu_res_t           wu_res;
  logic [1:0]        cr_fin;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start & ~busy;
  assign in_cmd = cmd_t'(in_command);

  // Word count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r <= WORDS_RESET;
    end else if (cfg_we) begin
      words_r <= cfg_wdata;
    end
  end

  // Effective word count: zero acts as one, anything above the depth as the depth.
  always_comb begin
    cfg_k = KW'(words_r);
    if (cfg_k == '0) begin
      n_k = KW'(1);
    end else if (cfg_k > KW'(MAX_WORDS)) begin
      n_k = KW'(MAX_WORDS);
    end else begin
      n_k = cfg_k;
    end
  end

  assign n_eff      = CW'(n_k);
  assign idx_ok     = KW'(in_word_index) < n_k;
  assign in_addr    = AW'(in_word_index);
  assign dist_ext   = SW'(in_shift_distance);
  assign len_bits   = SW'({n_eff, 6'b0});
  assign long_shift = dist_ext >= len_bits;
  assign dist_zero  = (in_shift_distance == '0);
  assign off        = CW'(dist_ext >> 6);

  // Decode a request: finish at once, or start a word walk.
  always_comb begin
    cmd_go    = in_cmd;
    go_run    = 1'b0;
    go_imm    = 1'b0;
    acc_we_in = 1'b0;
    opd_we_in = 1'b0;
    last_go   = n_eff - CW'(1);
    case (in_cmd)
      CMD_WRACC: begin
        go_imm    = 1'b1;
        acc_we_in = idx_ok;
      end
      CMD_WROPND: begin
        go_imm    = 1'b1;
        opd_we_in = idx_ok;
      end
      CMD_RDACC: begin
        go_run  = 1'b1;
        last_go = '0;
      end
      CMD_ADD, CMD_ADDSC, CMD_CMP, CMD_OR, CMD_AND, CMD_SETALL, CMD_CLRALL: begin
        go_run = 1'b1;
      end
      CMD_SHL: begin
        if (dist_zero) begin
          go_imm = 1'b1;
        end else if (long_shift) begin
          go_run = 1'b1;
          cmd_go = CMD_CLRALL;
        end else begin
          go_run  = 1'b1;
          last_go = n_eff;
        end
      end
      default: begin
        go_imm = 1'b1;
      end
    endcase
  end

  // Issue stage: read address and what the data stage does with the word.
  // A shift walks destinations from the top down with one lookahead read, so
  // each word is read before anything below it is overwritten.
  always_comb begin
    iss_addr   = AW'(cnt_r);
    iss_dst    = AW'(cnt_r);
    iss_wr     = 1'b1;
    iss_acc_en = 1'b1;
    iss_opd_en = 1'b0;
    case (cmd_r)
      CMD_RDACC: begin
        iss_addr   = idx_r;
        iss_dst    = idx_r;
        iss_wr     = 1'b0;
        iss_acc_en = idx_ok_r;
      end
      CMD_CMP: begin
        iss_addr   = AW'(n_r - CW'(1) - cnt_r);
        iss_wr     = 1'b0;
        iss_opd_en = 1'b1;
      end
      CMD_SHL: begin
        iss_addr   = AW'(base_r - cnt_r);
        iss_dst    = AW'(n_r - cnt_r);
        iss_wr     = (cnt_r != '0);
        iss_acc_en = (cnt_r <= base_r);
      end
      CMD_ADD, CMD_OR, CMD_AND: begin
        iss_opd_en = 1'b1;
      end
      default: begin
        iss_opd_en = 1'b0;
      end
    endcase
  end

  assign iss_acc_use = iss_acc_en & acc_vld_r[iss_addr];
  assign iss_opd_use = iss_opd_en & opd_vld_r[iss_addr];

  // Write ports: direct word writes while idle, write-back during a walk.
  assign acc_we    = (accept & acc_we_in) | (dv_r & d_wr_r);
  assign acc_waddr = dv_r ? d_dst_r : in_addr;
  assign acc_wdata = dv_r ? wu_res.wdata : in_value;
  assign opd_we    = accept & opd_we_in;

  wiu_ram #(
    .WIDTH (64),
    .DEPTH (MAX_WORDS)
  ) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (iss_addr),
    .rdata (acc_rdata)
  );

  wiu_ram #(
    .WIDTH (64),
    .DEPTH (MAX_WORDS)
  ) u_opd_ram (
    .clk   (clk),
    .we    (opd_we),
    .waddr (in_addr),
    .wdata (in_value),
    .raddr (iss_addr),
    .rdata (opd_rdata)
  );

  // Words never written, or outside the range, read as zero.
  assign acc_word = d_acc_use_r ? acc_rdata : '0;
  assign opd_word = d_opd_use_r ? opd_rdata : '0;

  assign wu_ctl.cmd   = cmd_r;
  assign wu_ctl.first = d_first_r;
  assign wu_ctl.carry = carry_r;
  assign wu_ctl.rem   = rem_r;

  wiu_word_unit u_word_unit (
    .ctl      (wu_ctl),
    .acc_word (acc_word),
    .opd_word (opd_word),
    .hi_word  (hi_r),
    .scalar   (val_r),
    .res      (wu_res)
  );

  // The first differing word from the top decides the compare.
  assign cr_fin = (cr_r != CMP_EQ) ? cr_r : wu_res.cmp;

  // Sequencer, result strobe and valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      dv_r        <= 1'b0;
      acc_vld_r   <= '0;
      opd_vld_r   <= '0;
    end else begin
      out_valid_r <= 1'b0;
      dv_r        <= (state_r == ST_ISSUE);
      case (state_r)
        ST_IDLE: begin
          if (accept && go_run) begin
            state_r <= ST_ISSUE;
          end else if (accept && go_imm) begin
            out_valid_r <= 1'b1;
          end
        end
        ST_ISSUE: begin
          if (cnt_r == last_r) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b1;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (acc_we) begin
        acc_vld_r[acc_waddr] <= 1'b1;
      end
      if (opd_we) begin
        opd_vld_r[in_addr] <= 1'b1;
      end
    end
  end

  // Request context, walk pipeline and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= cmd_go;
      n_r      <= n_eff;
      last_r   <= last_go;
      cnt_r    <= '0;
      base_r   <= n_eff - CW'(1) - off;
      rem_r    <= in_shift_distance[5:0];
      val_r    <= in_value;
      idx_r    <= in_addr;
      idx_ok_r <= idx_ok;
      carry_r  <= 1'b0;
      cr_r     <= CMP_EQ;
      hi_r     <= '0;
      if (go_imm) begin
        out_read_data_r <= '0;
        out_compare_r   <= CMP_EQ;
      end
    end
    if (state_r == ST_ISSUE) begin
      cnt_r       <= cnt_r + CW'(1);
      d_dst_r     <= iss_dst;
      d_wr_r      <= iss_wr;
      d_acc_use_r <= iss_acc_use;
      d_opd_use_r <= iss_opd_use;
      d_first_r   <= (cnt_r == '0);
    end
    if (dv_r) begin
      carry_r <= wu_res.carry;
      hi_r    <= acc_word;
      if (cmd_r == CMD_CMP) begin
        cr_r <= cr_fin;
      end
    end
    if (state_r == ST_DRAIN) begin
      out_read_data_r <= (cmd_r == CMD_RDACC) ? acc_word : '0;
      out_compare_r   <= (cmd_r == CMD_CMP) ? cr_fin : CMP_EQ;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_read_data_r;
  assign out_compare_result = $signed(out_compare_r);

endmodule
